/* hdl/rfdf_pkg.sv */
package rfdf_pkg;

  // field widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned KindW    = 2;
  localparam int unsigned PosW     = 6;
  localparam int unsigned AddrLenW = 3;
  localparam int unsigned PayLenW  = 6;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;

  // packet layout limits
  localparam logic [AddrLenW-1:0] AddrMin    = 3'd3;
  localparam logic [AddrLenW-1:0] AddrMax    = 3'd5;
  localparam logic [PayLenW-1:0]  PayMin     = 6'd1;
  localparam logic [PayLenW-1:0]  MaxPayload = 6'd32;

  // crc-16-ccitt
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  // output kind codes
  typedef enum logic [KindW-1:0] {
    KIND_ADDRESS = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_ADDRESS_BYTES = 2'd0,
    REG_PAYLOAD_BYTES = 2'd1
  } cfg_reg_e;

  // control from the framer to the crc unit
  typedef struct packed {
    logic init;
    logic update;
  } crc_ctrl_t;

  // one byte of msb-first crc update, unrolled over the eight bits
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [ByteW-1:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hdl/rfdf_if.sv */
// input byte channel
interface rfdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_req;

  modport source (output valid, output data_byte, output start_req, input ready);
  modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

// result channel
interface rfdf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] byte_kind;
  logic       crc_ok;
  logic       last;

  modport source (output valid, output out_byte, output byte_kind, output crc_ok,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input byte_kind, input crc_ok,
                  input last, output ready);
endinterface

// configuration write channel
interface rfdf_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [5:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/rfdf_crc16.sv */
module rfdf_crc16 (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rfdf_pkg::crc_ctrl_t ctrl_i,
  input  logic [7:0]          data_i,
  output logic [15:0]         crc_o
);
  import rfdf_pkg::*;

  logic [15:0] crc_q, crc_d;

  // restart on a preamble, fold in each address or payload byte
  always_comb begin
    crc_d = crc_q;
    if (ctrl_i.init) begin
      crc_d = CrcInit;
    end else if (ctrl_i.update) begin
      crc_d = crc16_byte(crc_q, data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcInit;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

/* hdl/rf_packet_deframer_crc16_unit.sv */
// Radio packet deframer with CRC-16-CCITT check.
// rx_i takes one packet byte per transaction; start_req marks the preamble,
// which opens a new packet (dropping any unfinished one) and gives no result.
// Then come address_bytes address bytes and payload_bytes payload bytes, each
// passed out on tx_o tagged KIND_ADDRESS or KIND_PAYLOAD, then a big-endian
// two-byte CRC. The first CRC byte gives no result; the second gives one
// KIND_STATUS result with last set and crc_ok high if the CRC matched. Bytes
// outside a packet are dropped. cfg_i writes the two length registers and is
// always ready; write them only while no packet is in flight.
// Path: a byte accepted on rx_i is held in the input register, then its result
// in the result register, which drives tx_o.
// Throughput: one byte per cycle while tx_o is not stalled; the CRC update is
// an unrolled 8-bit step. When tx_o stalls with a result pending, the input
// register still fills, then rx_i.ready drops until the result is taken.
// Reset: lengths go to 5 address and 32 payload bytes, no packet is active,
// both registers are empty.
module rf_packet_deframer_crc16_unit (
  input  logic clk_i,
  input  logic rst_ni,
  rfdf_in_if.sink    rx_i,
  rfdf_out_if.source tx_o,
  rfdf_cfg_if.sink   cfg_i
);
  import rfdf_pkg::*;

  // configuration registers
  logic [AddrLenW-1:0] addr_len_q;
  logic [PayLenW-1:0]  pay_len_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_len_q <= AddrMax;
      pay_len_q  <= MaxPayload;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_ADDRESS_BYTES: addr_len_q <= cfg_i.data[AddrLenW-1:0];
        REG_PAYLOAD_BYTES: pay_len_q  <= cfg_i.data[PayLenW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_start_q;
  logic             advance;
  logic             rx_fire;

  assign advance    = in_vld_q && (!tx_o.valid || tx_o.ready);
  assign rx_i.ready = !in_vld_q || advance;
  assign rx_fire    = rx_i.valid && rx_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      in_byte_q  <= rx_i.data_byte;
      in_start_q <= rx_i.start_req;
    end
  end

  // clamp lengths into the supported layout
  logic [AddrLenW-1:0] eff_addr;
  logic [PayLenW-1:0]  eff_pay;
  logic [PosW-1:0]     body_len;

  always_comb begin
    eff_addr = addr_len_q;
    if (addr_len_q < AddrMin) eff_addr = AddrMin;
    if (addr_len_q > AddrMax) eff_addr = AddrMax;
    eff_pay = pay_len_q;
    if (pay_len_q < PayMin)     eff_pay = PayMin;
    if (pay_len_q > MaxPayload) eff_pay = MaxPayload;
  end

  assign body_len = PosW'(eff_addr) + eff_pay;

  // framing state
  logic             active_q, active_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] crc_hi_q, crc_hi_d;
  logic [15:0]      crc_val;
  crc_ctrl_t        crc_ctrl;

  logic             emit;
  logic [ByteW-1:0] res_byte;
  kind_e            res_kind;
  logic             res_ok;
  logic             res_last;

  always_comb begin
    active_d = active_q;
    pos_d    = pos_q;
    crc_hi_d = crc_hi_q;
    crc_ctrl = '0;
    emit     = 1'b0;
    res_byte = '0;
    res_kind = KIND_ADDRESS;
    res_ok   = 1'b0;
    res_last = 1'b0;
    if (advance) begin
      if (in_start_q) begin
        active_d      = 1'b1;
        pos_d         = '0;
        crc_hi_d      = '0;
        crc_ctrl.init = 1'b1;
      end else if (active_q) begin
        if (pos_q < body_len) begin
          // address or payload byte
          crc_ctrl.update = 1'b1;
          emit     = 1'b1;
          res_byte = in_byte_q;
          res_kind = (pos_q < PosW'(eff_addr)) ? KIND_ADDRESS : KIND_PAYLOAD;
          pos_d    = pos_q + 1'b1;
        end else if (pos_q == body_len) begin
          // high crc byte
          crc_hi_d = in_byte_q;
          pos_d    = pos_q + 1'b1;
        end else begin
          // low crc byte closes the packet
          emit     = 1'b1;
          res_kind = KIND_STATUS;
          res_ok   = ({crc_hi_q, in_byte_q} == crc_val);
          res_last = 1'b1;
          active_d = 1'b0;
          pos_d    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pos_q    <= '0;
      crc_hi_q <= '0;
    end else begin
      active_q <= active_d;
      pos_q    <= pos_d;
      crc_hi_q <= crc_hi_d;
    end
  end

  rfdf_crc16 u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .data_i (in_byte_q),
    .crc_o  (crc_val)
  );

  // result register
  logic             out_vld_q;
  logic [ByteW-1:0] out_byte_q;
  kind_e            out_kind_q;
  logic             out_ok_q;
  logic             out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (tx_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= res_byte;
      out_kind_q <= res_kind;
      out_ok_q   <= res_ok;
      out_last_q <= res_last;
    end
  end

  assign tx_o.valid     = out_vld_q;
  assign tx_o.out_byte  = out_byte_q;
  assign tx_o.byte_kind = out_kind_q;
  assign tx_o.crc_ok    = out_ok_q;
  assign tx_o.last      = out_last_q;

endmodule

/* hdl/rfdf_checker.sv */
module rfdf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rx_valid_i,
  input logic       rx_ready_i,
  input logic       tx_valid_i,
  input logic       tx_ready_i,
  input logic [7:0] tx_byte_i,
  input logic [1:0] tx_kind_i,
  input logic       tx_ok_i,
  input logic       tx_last_i
);
  import rfdf_pkg::*;

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_i && !tx_ready_i |=> tx_valid_i && $stable(tx_byte_i) && $stable(tx_kind_i)
      && $stable(tx_ok_i) && $stable(tx_last_i))
    else $error("result changed while stalled");

  // data transactions carry no status flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_i && tx_kind_i != KIND_STATUS |-> !tx_last_i && !tx_ok_i)
    else $error("status flag on a data transaction");

  // status transactions close the packet and carry a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_i && tx_kind_i == KIND_STATUS |-> tx_last_i && tx_byte_i == 8'h00)
    else $error("malformed status transaction");

  // a newly raised result must follow an accepted input transaction or an earlier result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(tx_valid_i) |-> $past(rx_valid_i && rx_ready_i, 2) || $past(tx_valid_i, 2)
      || $past(rx_valid_i && rx_ready_i, 3))
    else $error("result without a preceding input");

endmodule

bind rf_packet_deframer_crc16_unit rfdf_checker u_rfdf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .rx_valid_i (rx_i.valid),
  .rx_ready_i (rx_i.ready),
  .tx_valid_i (tx_o.valid),
  .tx_ready_i (tx_o.ready),
  .tx_byte_i  (tx_o.out_byte),
  .tx_kind_i  (tx_o.byte_kind),
  .tx_ok_i    (tx_o.crc_ok),
  .tx_last_i  (tx_o.last)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import rfdf_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned IdlePct    = 36;
  // an index past the two length registers, writes to it are dropped
  localparam logic [CfgIdxW-1:0] RegBeyondList = 2'd3;

  typedef struct {
    logic [ByteW-1:0] data;
    kind_e            kind;
    logic             crc_ok;
    logic             last;
  } out_rec_t;

  logic clk_i;
  logic rst_ni;

  rfdf_in_if  rx ();
  rfdf_out_if tx ();
  rfdf_cfg_if cfg ();

  rf_packet_deframer_crc16_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx),
    .tx_o   (tx),
    .cfg_i  (cfg)
  );

  // deframer shadow state and length registers
  logic [AddrLenW-1:0] addr_len_q;
  logic [PayLenW-1:0]  pay_len_q;
  logic [PosW-1:0]     pos_q;
  logic                active_q;
  logic [15:0]         crc_q;
  logic [ByteW-1:0]    crc_hi_q;

  out_rec_t    expected_q[$];
  int unsigned mismatches  = 0;
  int unsigned cycles      = 0;
  int unsigned frame_bytes = 0;
  int unsigned tx_hold     = 0;
  bit          rx_idle_en  = 1'b1;
  bit          tx_idle_en  = 1'b1;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // effective lengths after clamping
  function automatic int unsigned addr_span();
    if (addr_len_q < AddrMin) return AddrMin;
    if (addr_len_q > AddrMax) return AddrMax;
    return addr_len_q;
  endfunction

  function automatic int unsigned pay_span();
    if (pay_len_q < PayMin) return PayMin;
    if (pay_len_q > MaxPayload) return MaxPayload;
    return pay_len_q;
  endfunction

  // bit-serial ccitt update, msb of the byte first
  function automatic logic [15:0] ccitt_next(logic [15:0] crc, logic [ByteW-1:0] d);
    logic fb;
    for (int i = ByteW - 1; i >= 0; i--) begin
      fb  = crc[15] ^ d[i];
      crc = {crc[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return crc;
  endfunction

  // advance the deframer by one accepted byte and queue what it emits
  function automatic void deframe_byte(logic [ByteW-1:0] data, logic start);
    int unsigned a;
    int unsigned p;
    out_rec_t    r;
    a = addr_span();
    p = pay_span();
    if (start) begin
      active_q = 1'b1;
      pos_q    = '0;
      crc_q    = CrcInit;
      crc_hi_q = '0;
    end else if (active_q) begin
      if (pos_q < a + p) begin
        crc_q    = ccitt_next(crc_q, data);
        r.data   = data;
        r.kind   = (pos_q < a) ? KIND_ADDRESS : KIND_PAYLOAD;
        r.crc_ok = 1'b0;
        r.last   = 1'b0;
        expected_q.push_back(r);
        pos_q = pos_q + 1'b1;
      end else if (pos_q == a + p) begin
        crc_hi_q = data;
        pos_q    = pos_q + 1'b1;
      end else begin
        r.data   = '0;
        r.kind   = KIND_STATUS;
        r.crc_ok = ({crc_hi_q, data} == crc_q);
        r.last   = 1'b1;
        expected_q.push_back(r);
        active_q = 1'b0;
        pos_q    = '0;
      end
    end
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    out_rec_t want;
    if (rst_ni && tx.valid && tx.ready) begin
      if (expected_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected transaction byte=%02h kind=%0d ok=%0b last=%0b",
                                tx.out_byte, tx.byte_kind, tx.crc_ok, tx.last));
      end else begin
        want = expected_q.pop_front();
        if (tx.out_byte !== want.data || tx.byte_kind !== want.kind ||
            tx.crc_ok !== want.crc_ok || tx.last !== want.last) begin
          flag_mismatch($sformatf(
            "expected byte=%02h kind=%0d ok=%0b last=%0b, got byte=%02h kind=%0d ok=%0b last=%0b",
            want.data, want.kind, want.crc_ok, want.last,
            tx.out_byte, tx.byte_kind, tx.crc_ok, tx.last));
        end
      end
    end
  end

  // result receiver: random stalls, or a counted hold-off
  initial begin
    tx.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (tx_hold > 0) begin
        tx.ready <= 1'b0;
        tx_hold--;
      end else begin
        tx.ready <= !tx_idle_en || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // offer one byte and wait for its transaction
  task automatic send_byte(input logic [ByteW-1:0] data, input logic start);
    @(negedge clk_i);
    while (rx_idle_en && $urandom_range(99) < IdlePct) begin
      rx.valid <= 1'b0;
      @(negedge clk_i);
    end
    rx.valid     <= 1'b1;
    rx.data_byte <= data;
    rx.start_req <= start;
    do @(posedge clk_i); while (!rx.ready);
    deframe_byte(data, start);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk_i); while (!cfg.ready);
    case (idx)
      REG_ADDRESS_BYTES: addr_len_q = value[AddrLenW-1:0];
      REG_PAYLOAD_BYTES: pay_len_q = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  // stop offering, wait for every result, then cover bytes that give none
  task automatic settle();
    @(negedge clk_i);
    rx.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // preamble, body, crc high then low; cut limits the bytes after the preamble
  task automatic send_framed(input logic [ByteW-1:0] pre, input logic [ByteW-1:0] body[$],
                             input logic [15:0] crc_flip, input int unsigned cut);
    logic [15:0]      sum;
    logic [ByteW-1:0] stream[$];
    sum = CrcInit;
    foreach (body[i]) sum = ccitt_next(sum, body[i]);
    sum ^= crc_flip;
    stream = body;
    stream.push_back(sum[15:8]);
    stream.push_back(sum[7:0]);
    send_byte(pre, 1'b1);
    frame_bytes++;
    foreach (stream[i]) begin
      if (i < cut) begin
        send_byte(stream[i], 1'b0);
        frame_bytes++;
      end
    end
  endtask

  // random packet at the current lengths: good, corrupted, cut short, or noise
  task automatic random_packet();
    logic [ByteW-1:0] body[$];
    int unsigned      n;
    int unsigned      r;
    n = addr_span() + pay_span();
    repeat (n) body.push_back(ByteW'($urandom_range(255)));
    r = $urandom_range(99);
    if (r < 8) begin
      repeat ($urandom_range(1, 3)) send_byte(ByteW'($urandom_range(255)), 1'b0);
    end else if (r < 18) begin
      send_framed(ByteW'($urandom_range(255)), body, 16'h0000, $urandom_range(n + 1));
    end else if (r < 36) begin
      send_framed(ByteW'($urandom_range(255)), body, 16'(1 << $urandom_range(15)), n + 2);
    end else begin
      send_framed(ByteW'($urandom_range(255)), body, 16'h0000, n + 2);
    end
  endtask

  task automatic run_phase(input logic [CfgDataW-1:0] addr_val,
                           input logic [CfgDataW-1:0] pay_val, input int unsigned n);
    int unsigned first;
    settle();
    write_reg(REG_ADDRESS_BYTES, addr_val);
    write_reg(REG_PAYLOAD_BYTES, pay_val);
    first = frame_bytes;
    while (frame_bytes - first < n) random_packet();
  endtask

  // bytes with no packet open are dropped
  task automatic test_ignored_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  // shortest layout, matching and broken crc, spare index write
  task automatic test_crc_check();
    logic [ByteW-1:0] pkt[$];
    settle();
    write_reg(REG_ADDRESS_BYTES, 6'd3);
    write_reg(REG_PAYLOAD_BYTES, 6'd1);
    write_reg(RegBeyondList, 6'h3F);
    pkt = '{8'h00, 8'hFF, 8'h80, 8'h01};
    send_framed(8'hFF, pkt, 16'h0000, 6);
    send_framed(8'h00, pkt, 16'h8001, 6);
  endtask

  // a new preamble drops the open packet without status
  task automatic test_restart();
    logic [ByteW-1:0] pkt[$];
    pkt = '{8'hA5, 8'h5A, 8'hC3, 8'h3C};
    send_framed(8'h55, pkt, 16'h0000, 2);
    send_framed(8'hAA, pkt, 16'h0000, 6);
  endtask

  // shrink the layout under an open packet so the next byte closes it
  task automatic test_length_change();
    logic [ByteW-1:0] pkt[$];
    settle();
    write_reg(REG_PAYLOAD_BYTES, 6'd4);
    pkt = '{8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE};
    send_framed(8'h7E, pkt, 16'h0000, 5);
    settle();
    write_reg(REG_PAYLOAD_BYTES, 6'd1);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h0F, 1'b0);
  endtask

  // block fills while the receiver holds off
  task automatic test_backpressure();
    settle();
    write_reg(REG_ADDRESS_BYTES, 6'd4);
    write_reg(REG_PAYLOAD_BYTES, 6'd10);
    rx_idle_en = 1'b0;
    tx_hold    = 300;
    run_phase(6'd4, 6'd10, 60);
    rx_idle_en = 1'b1;
  endtask

  // long stretch with neither side idling
  task automatic test_no_idle();
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    run_phase(6'd5, 6'd32, 150);
    rx_idle_en = 1'b1;
    tx_idle_en = 1'b1;
  endtask

  // random packets over extreme, clamped and random lengths
  task automatic test_random_lengths();
    run_phase(6'd3, 6'd1, 125);
    run_phase(6'd5, 6'd32, 125);
    run_phase(6'h2C, 6'd17, 125);
    run_phase(6'd0, 6'd0, 125);
    run_phase(6'h3F, 6'h3F, 125);
    run_phase(6'd2, 6'd33, 125);
    run_phase(6'h3E, 6'd2, 125);
    run_phase(CfgDataW'($urandom_range(63)), CfgDataW'($urandom_range(63)), 125);
    run_phase(CfgDataW'($urandom_range(63)), CfgDataW'($urandom_range(63)), 125);
  endtask

  initial begin
    rst_ni        = 1'b0;
    rx.valid      = 1'b0;
    rx.data_byte  = '0;
    rx.start_req  = 1'b0;
    cfg.valid     = 1'b0;
    cfg.index     = REG_ADDRESS_BYTES;
    cfg.data      = '0;
    addr_len_q    = AddrMax;
    pay_len_q     = MaxPayload;
    pos_q         = '0;
    active_q      = 1'b0;
    crc_q         = CrcInit;
    crc_hi_q      = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_ignored_bytes();
    test_crc_check();
    test_restart();
    test_length_change();
    test_backpressure();
    test_no_idle();
    test_random_lengths();

    settle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
